### rtl/core/obb2d_pkg.sv
// package for the 2d oriented box separating axis test
// field layout of the request word, axis and pair index tables
// no dependencies
package obb2d_pkg;

   localparam int FIELD_WIDTH         = 32;
   localparam int FIELD_COUNT         = 12;
   localparam int REQ_DATA_WIDTH      = FIELD_WIDTH * FIELD_COUNT;
   localparam int RSP_DATA_WIDTH      = 8;
   localparam int COORD_WIDTH_DEFAULT = 32;

   localparam int AXIS_COUNT = 4;
   localparam int PAIR_COUNT = 10;

   // field positions in the request word, lowest first
   localparam int FIELD_A_CENTER_X = 0;
   localparam int FIELD_A_CENTER_Y = 1;
   localparam int FIELD_A_AXIS_U_X = 2;
   localparam int FIELD_A_AXIS_U_Y = 3;
   localparam int FIELD_A_AXIS_V_X = 4;
   localparam int FIELD_A_AXIS_V_Y = 5;
   localparam int FIELD_B_CENTER_X = 6;
   localparam int FIELD_B_CENTER_Y = 7;
   localparam int FIELD_B_AXIS_U_X = 8;
   localparam int FIELD_B_AXIS_U_Y = 9;
   localparam int FIELD_B_AXIS_V_X = 10;
   localparam int FIELD_B_AXIS_V_Y = 11;

   // the u and v edge vectors of boxes a and b used as candidate axes
   localparam int EDGE_X_FIELD [AXIS_COUNT] = '{FIELD_A_AXIS_U_X, FIELD_A_AXIS_V_X,
                                                FIELD_B_AXIS_U_X, FIELD_B_AXIS_V_X};
   localparam int EDGE_Y_FIELD [AXIS_COUNT] = '{FIELD_A_AXIS_U_Y, FIELD_A_AXIS_V_Y,
                                                FIELD_B_AXIS_U_Y, FIELD_B_AXIS_V_Y};

   // unordered edge pairs, edge dot products are symmetric
   localparam int PAIR_FIRST  [PAIR_COUNT] = '{0, 0, 0, 0, 1, 1, 1, 2, 2, 3};
   localparam int PAIR_SECOND [PAIR_COUNT] = '{0, 1, 2, 3, 1, 2, 3, 2, 3, 3};
   localparam int PAIR_OF [AXIS_COUNT][AXIS_COUNT] = '{'{0, 1, 2, 3},
                                                      '{1, 4, 5, 6},
                                                      '{2, 5, 7, 8},
                                                      '{3, 6, 8, 9}};

endpackage

### rtl/core/obb2d_separating_axis_test_top.sv
// top level of the 2d oriented box separating axis test
// four stage pipeline: input, products, absolute dots, sum and compare
// depends on obb2d_pkg
//
//   channel | ports            | transfer contents
//   --------+------------------+------------------------------------------
//   request | req_tvalid/tready| twelve 32-bit coordinates of boxes a and b
//   result  | rsp_tvalid/tready| overlap flag
//
// one box pair per cycle while the result is not stalled; each request passes the
// input register, the product stage, the absolute dot stage and the sum and
// compare stage in that order before its result is valid
// a stalled result freezes the whole pipeline, req_tready follows
// rsp_tready when the result register is full
// synchronous reset clears the valid bits only
module obb2d_separating_axis_test_top
   import obb2d_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // a_center_x, a_center_y, a_axis_u_x, a_axis_u_y, a_axis_v_x, a_axis_v_y,
   // b_center_x, b_center_y, b_axis_u_x, b_axis_u_y, b_axis_v_x, b_axis_v_y
   input  logic [REQ_DATA_WIDTH-1:0] req_tdata,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // overlap, then zero fill
   output logic [RSP_DATA_WIDTH-1:0] rsp_tdata
);

   localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
   localparam int PROD_D_WIDTH = 2 * COORD_WIDTH + 1;
   localparam int PROD_E_WIDTH = 2 * COORD_WIDTH;
   localparam int DOT_WIDTH   = 2 * COORD_WIDTH + 2;
   localparam int SUM_WIDTH   = DOT_WIDTH + 1;

   logic advance;

   // input register
   logic                          in_valid_ff;
   logic signed [COORD_WIDTH-1:0] coord_in [FIELD_COUNT];
   logic signed [COORD_WIDTH-1:0] coord_ff [FIELD_COUNT];

   // product stage
   logic signed [DIFF_WIDTH-1:0]   dx;
   logic signed [DIFF_WIDTH-1:0]   dy;
   logic                           prod_valid_ff;
   logic signed [PROD_D_WIDTH-1:0] pd_x_in [AXIS_COUNT];
   logic signed [PROD_D_WIDTH-1:0] pd_y_in [AXIS_COUNT];
   logic signed [PROD_D_WIDTH-1:0] pd_x_ff [AXIS_COUNT];
   logic signed [PROD_D_WIDTH-1:0] pd_y_ff [AXIS_COUNT];
   logic signed [PROD_E_WIDTH-1:0] pe_x_in [PAIR_COUNT];
   logic signed [PROD_E_WIDTH-1:0] pe_y_in [PAIR_COUNT];
   logic signed [PROD_E_WIDTH-1:0] pe_x_ff [PAIR_COUNT];
   logic signed [PROD_E_WIDTH-1:0] pe_y_ff [PAIR_COUNT];

   // absolute dot stage
   logic signed [DOT_WIDTH-1:0] dot_d [AXIS_COUNT];
   logic signed [DOT_WIDTH-1:0] dot_e [PAIR_COUNT];
   logic                        abs_valid_ff;
   logic [DOT_WIDTH-1:0]        abs_d_in [AXIS_COUNT];
   logic [DOT_WIDTH-1:0]        abs_d_ff [AXIS_COUNT];
   logic [DOT_WIDTH-1:0]        abs_e_in [PAIR_COUNT];
   logic [DOT_WIDTH-1:0]        abs_e_ff [PAIR_COUNT];
   logic                        abs_d_zero;

   // sum and compare stage
   logic [SUM_WIDTH-1:0] lhs [AXIS_COUNT];
   logic [SUM_WIDTH-1:0] rhs [AXIS_COUNT];
   logic                 separated;
   logic                 rsp_valid_ff;
   logic                 overlap_in;
   logic                 overlap_ff;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_WIDTH-1){1'b0}}, overlap_ff};

   always_comb begin
      for (int f = 0; f < FIELD_COUNT; f++) begin
         coord_in[f] = $signed(req_tdata[f*FIELD_WIDTH +: COORD_WIDTH]);
      end
   end

   always_comb begin
      dx = DIFF_WIDTH'(coord_ff[FIELD_B_CENTER_X]) - DIFF_WIDTH'(coord_ff[FIELD_A_CENTER_X]);
      dy = DIFF_WIDTH'(coord_ff[FIELD_B_CENTER_Y]) - DIFF_WIDTH'(coord_ff[FIELD_A_CENTER_Y]);
      for (int i = 0; i < AXIS_COUNT; i++) begin
         pd_x_in[i] = PROD_D_WIDTH'(dx) * PROD_D_WIDTH'(coord_ff[EDGE_X_FIELD[i]]);
         pd_y_in[i] = PROD_D_WIDTH'(dy) * PROD_D_WIDTH'(coord_ff[EDGE_Y_FIELD[i]]);
      end
      for (int k = 0; k < PAIR_COUNT; k++) begin
         pe_x_in[k] = PROD_E_WIDTH'(coord_ff[EDGE_X_FIELD[PAIR_FIRST[k]]])
                    * PROD_E_WIDTH'(coord_ff[EDGE_X_FIELD[PAIR_SECOND[k]]]);
         pe_y_in[k] = PROD_E_WIDTH'(coord_ff[EDGE_Y_FIELD[PAIR_FIRST[k]]])
                    * PROD_E_WIDTH'(coord_ff[EDGE_Y_FIELD[PAIR_SECOND[k]]]);
      end
   end

   always_comb begin
      abs_d_zero = 1'b1;
      for (int i = 0; i < AXIS_COUNT; i++) begin
         dot_d[i]    = DOT_WIDTH'(pd_x_ff[i]) + DOT_WIDTH'(pd_y_ff[i]);
         abs_d_in[i] = dot_d[i][DOT_WIDTH-1] ? DOT_WIDTH'(-dot_d[i]) : DOT_WIDTH'(dot_d[i]);
         abs_d_zero  = abs_d_zero && (abs_d_ff[i] == '0);
      end
      for (int k = 0; k < PAIR_COUNT; k++) begin
         dot_e[k]    = DOT_WIDTH'(pe_x_ff[k]) + DOT_WIDTH'(pe_y_ff[k]);
         abs_e_in[k] = dot_e[k][DOT_WIDTH-1] ? DOT_WIDTH'(-dot_e[k]) : DOT_WIDTH'(dot_e[k]);
      end
   end

   // axis separates when twice the center projection beats the edge sum
   always_comb begin
      separated = 1'b0;
      for (int i = 0; i < AXIS_COUNT; i++) begin
         lhs[i] = {abs_d_ff[i], 1'b0};
         rhs[i] = '0;
         for (int j = 0; j < AXIS_COUNT; j++) begin
            rhs[i] = rhs[i] + SUM_WIDTH'(abs_e_ff[PAIR_OF[i][j]]);
         end
         separated = separated || (lhs[i] > rhs[i]);
      end
      overlap_in = !separated;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         prod_valid_ff <= 1'b0;
         abs_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else if (advance) begin
         in_valid_ff   <= req_tvalid;
         prod_valid_ff <= in_valid_ff;
         abs_valid_ff  <= prod_valid_ff;
         rsp_valid_ff  <= abs_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         coord_ff   <= coord_in;
         pd_x_ff    <= pd_x_in;
         pd_y_ff    <= pd_y_in;
         pe_x_ff    <= pe_x_in;
         pe_y_ff    <= pe_y_in;
         abs_d_ff   <= abs_d_in;
         abs_e_ff   <= abs_e_in;
         overlap_ff <= overlap_in;
      end
   end

   a_stall_freezes_pipe: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=>
         $stable({in_valid_ff, prod_valid_ff, abs_valid_ff, rsp_valid_ff}))
      else $error("pipeline moved during result stall");

   a_input_moves_on: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && advance) |=> prod_valid_ff)
      else $error("input stage item lost");

   a_zero_center_overlaps: assert property (@(posedge clock) disable iff (reset)
      (abs_valid_ff && advance && abs_d_zero) |=> (rsp_valid_ff && overlap_ff))
      else $error("coincident centers reported as separated");

endmodule

### tb/tb.sv
// testbench for obb2d_separating_axis_test_top, the 2d oriented box overlap test
// predicts each overlap flag with exact 128-bit arithmetic and checks it in order
// depends on obb2d_pkg and the top level rtl
`timescale 1ns / 1ps

module tb
   import obb2d_pkg::*;
();

   localparam int CW          = COORD_WIDTH_DEFAULT;
   localparam int ONE         = 32'h0001_0000;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN       = 16;

   typedef logic [REQ_DATA_WIDTH-1:0] pair_word_type;
   typedef logic signed [127:0] wide_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_WIDTH-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;

   logic overlap_q[$];
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int error_count = 0;
   int pairs_sent = 0;
   int results_seen = 0;
   int overlaps_seen = 0;
   int cycle_count = 0;

   obb2d_separating_axis_test_top #(.COORD_WIDTH(CW)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic wide_type coord_ext(input logic [FIELD_WIDTH-1:0] v);
      wide_type r;
      for (int i = 0; i < 128; i++) begin
         r[i] = (i < CW) ? v[i] : v[CW-1];
      end
      return r;
   endfunction

   function automatic wide_type abs_wide(input wide_type v);
      return (v < 0) ? -v : v;
   endfunction

   // exact separating axis test over the u and v edge axes of both boxes
   function automatic logic predict_overlap(input pair_word_type w);
      wide_type ex[AXIS_COUNT];
      wide_type ey[AXIS_COUNT];
      wide_type dx, dy, lhs, rhs;
      logic  separated;
      separated = 1'b0;
      dx = coord_ext(w[FIELD_B_CENTER_X*FIELD_WIDTH +: FIELD_WIDTH])
         - coord_ext(w[FIELD_A_CENTER_X*FIELD_WIDTH +: FIELD_WIDTH]);
      dy = coord_ext(w[FIELD_B_CENTER_Y*FIELD_WIDTH +: FIELD_WIDTH])
         - coord_ext(w[FIELD_A_CENTER_Y*FIELD_WIDTH +: FIELD_WIDTH]);
      for (int i = 0; i < AXIS_COUNT; i++) begin
         ex[i] = coord_ext(w[EDGE_X_FIELD[i]*FIELD_WIDTH +: FIELD_WIDTH]);
         ey[i] = coord_ext(w[EDGE_Y_FIELD[i]*FIELD_WIDTH +: FIELD_WIDTH]);
      end
      for (int i = 0; i < AXIS_COUNT; i++) begin
         lhs = abs_wide(dx * ex[i] + dy * ey[i]) <<< 1;
         rhs = '0;
         for (int j = 0; j < AXIS_COUNT; j++) begin
            rhs = rhs + abs_wide(ex[j] * ex[i] + ey[j] * ey[i]);
         end
         if (lhs > rhs) separated = 1'b1;
      end
      return !separated;
   endfunction

   function automatic pair_word_type pack_boxes(input int acx, input int acy,
                                                input int aux, input int auy,
                                                input int avx, input int avy,
                                                input int bcx, input int bcy,
                                                input int bux, input int buy,
                                                input int bvx, input int bvy);
      return {bvy, bvx, buy, bux, bcy, bcx, avy, avx, auy, aux, acy, acx};
   endfunction

   function automatic int rand_signed(input int unsigned mag);
      return int'($urandom_range(2 * mag, 0)) - int'(mag);
   endfunction

   // rotated and scaled boxes placed close enough that both outcomes are common
   function automatic pair_word_type random_box_pair();
      int s, k, ux, uy, vx, vy, wx, wy, zx, zy, acx, acy, reach;
      int unsigned mag;
      s = $urandom_range(24, 4);
      mag = 1 << s;
      ux = rand_signed(mag);
      uy = rand_signed(mag);
      if ($urandom_range(1, 0)) begin
         k = $urandom_range(8, 1);
         vx = -(uy / 4) * k;
         vy = (ux / 4) * k;
      end else begin
         vx = rand_signed(mag);
         vy = rand_signed(mag);
      end
      wx = rand_signed(mag);
      wy = rand_signed(mag);
      if ($urandom_range(1, 0)) begin
         k = $urandom_range(8, 1);
         zx = -(wy / 4) * k;
         zy = (wx / 4) * k;
      end else begin
         zx = rand_signed(mag);
         zy = rand_signed(mag);
      end
      // an edge collapsed to a point now and then
      case ($urandom_range(19, 0))
         0: begin ux = 0; uy = 0; end
         1: begin zx = 0; zy = 0; end
         default: ;
      endcase
      acx = rand_signed(1 << 29);
      acy = rand_signed(1 << 29);
      reach = 3 << s;
      return pack_boxes(acx, acy, ux, uy, vx, vy,
                        acx + rand_signed(reach), acy + rand_signed(reach),
                        wx, wy, zx, zy);
   endfunction

   // axis-aligned squares of edge m, exactly touching or one lsb apart
   function automatic pair_word_type touching_pair();
      int m, gap, sx, sy;
      m = 1 << $urandom_range(24, 1);
      gap = $urandom_range(1, 0);
      sx = $urandom_range(1, 0) ? 1 : -1;
      sy = $urandom_range(1, 0) ? 1 : -1;
      if ($urandom_range(1, 0))
         return pack_boxes(0, 0, m, 0, 0, m, sx * (m + gap), sy * m / 2, m, 0, 0, m);
      return pack_boxes(0, 0, m, 0, 0, m, sx * m / 2, sy * (m + gap), 0, m, m, 0);
   endfunction

   function automatic pair_word_type noise_pair();
      pair_word_type w;
      for (int i = 0; i < FIELD_COUNT; i++) begin
         w[i*FIELD_WIDTH +: FIELD_WIDTH] = $urandom;
      end
      return w;
   endfunction

   // receiver side stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
      end
   end

   // result checker
   always @(posedge clock) begin
      logic want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (rsp_tdata[0]) overlaps_seen++;
         if (overlap_q.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("unexpected result transfer: rsp_tdata=%h", rsp_tdata);
         end else begin
            want = overlap_q.pop_front();
            if (rsp_tdata !== {{(RSP_DATA_WIDTH-1){1'b0}}, want}) begin
               error_count++;
               if (error_count <= 10)
                  $display("mismatch on result %0d: expected overlap %b, got rsp_tdata %h",
                           results_seen, want, rsp_tdata);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, overlap_q.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic send_pair(input pair_word_type w);
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      overlap_q.push_back(predict_overlap(w));
      req_tvalid <= 1'b1;
      req_tdata  <= w;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pairs_sent++;
   endtask

   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (overlap_q.size() != 0) @(posedge clock);
   endtask

   task automatic test_edge_cases();
      send_pair(pack_boxes(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_pair(pack_boxes(0, 0, ONE, 0, 0, ONE, 0, 0, ONE, 0, 0, ONE));
      // touching squares and the first step apart
      send_pair(pack_boxes(0, 0, ONE, 0, 0, ONE, ONE, 0, ONE, 0, 0, ONE));
      send_pair(pack_boxes(0, 0, ONE, 0, 0, ONE, ONE + 1, 0, ONE, 0, 0, ONE));
      send_pair(pack_boxes(0, 0, ONE, 0, 0, ONE, 0, -ONE, ONE, 0, 0, ONE));
      send_pair(pack_boxes(0, 0, ONE, 0, 0, ONE, 0, -ONE - 1, ONE, 0, 0, ONE));
      // zero-length edges
      send_pair(pack_boxes(0, 0, 0, 0, 0, 0, 10 * ONE, 0, ONE, 0, 0, ONE));
      send_pair(pack_boxes(0, 0, 0, 0, 0, 0, 10 * ONE, 3 * ONE, 0, 0, 0, 0));
      send_pair(pack_boxes(0, 0, ONE, 0, 0, 0, 2 * ONE, 0, 0, 0, 0, ONE));
      // rotated by 45 degrees against an aligned box
      send_pair(pack_boxes(0, 0, ONE, ONE, -ONE, ONE, 2 * ONE, 0, ONE, 0, 0, ONE));
      send_pair(pack_boxes(0, 0, ONE, ONE, -ONE, ONE, 3 * ONE, 3 * ONE, ONE, 0, 0, ONE));
      // collinear edges
      send_pair(pack_boxes(0, 0, ONE, ONE, ONE, ONE, ONE, -ONE, ONE, 0, ONE, 0));
      // field extremes
      send_pair({FIELD_COUNT{32'h7FFF_FFFF}});
      send_pair({FIELD_COUNT{32'h8000_0000}});
      send_pair(pack_boxes(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                           32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                           32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
      send_pair(pack_boxes(32'h7FFF_FFFF, 32'h8000_0000, 1, 0, 0, 1,
                           32'h8000_0000, 32'h7FFF_FFFF, -1, 0, 0, -1));
      send_pair({FIELD_COUNT{32'h5555_5555}});
      send_pair({FIELD_COUNT{32'hAAAA_AAAA}});
      send_pair({FIELD_COUNT{32'hFFFF_FFFF}});
      wait_for_results();
   endtask

   task automatic test_random_boxes(input int count, input int send_pct, input int recv_pct);
      int r;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(99, 0);
         if (r < 78)
            send_pair(random_box_pair());
         else if (r < 93)
            send_pair(noise_pair());
         else
            send_pair(touching_pair());
         // hold off now and then until the pipeline has emptied
         if ($urandom_range(199, 0) == 0) wait_for_results();
      end
      wait_for_results();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_edge_cases();
      test_random_boxes(545, 37, 66);
      test_random_boxes(545, 66, 37);
      test_random_boxes(545, 0, 0);
      repeat (DRAIN) @(posedge clock);
      $display("covered %0d box pairs: edge cases, rotated boxes, touching pairs and noise",
               pairs_sent);
      $display("%0d results checked, %0d overlapping, %0d errors",
               results_seen, overlaps_seen, error_count);
      if (error_count == 0 && overlap_q.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

### files.f
rtl/core/obb2d_pkg.sv
rtl/core/obb2d_separating_axis_test_top.sv
tb/tb.sv
